// File: hdl/snmpber_pkg.sv
// Shared types, tag constants and helper functions for the SNMP BER parser.
// Used by snmpber_step, snmpber_fifo and snmp_ber_message_parser_core.
package snmpber_pkg;

    // Results one input byte can cause at most
    localparam int MAX_RES = 3;

    // Record queue geometry
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int SPACE_LIMIT = FIFO_DEPTH - MAX_RES;

    // BER tags
    localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
    localparam logic [7:0] TAG_INTEGER      = 8'h02;
    localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
    localparam logic [7:0] TAG_GET          = 8'hA0;
    localparam logic [7:0] TAG_GET_NEXT     = 8'hA1;
    localparam logic [7:0] TAG_RESPONSE     = 8'hA2;
    localparam logic [7:0] TAG_SET          = 8'hA3;
    localparam logic [7:0] TAG_OID          = 8'h06;
    localparam logic [7:0] TAG_IP_ADDRESS   = 8'h40;
    localparam logic [7:0] TAG_NULL         = 8'h05;

    // First OID byte packs two components
    localparam int OID_RADIX = 40;

    // Record kinds
    localparam logic [3:0] REC_VERSION      = 4'd0;
    localparam logic [3:0] REC_COMMUNITY    = 4'd1;
    localparam logic [3:0] REC_PDU_KIND     = 4'd2;
    localparam logic [3:0] REC_REQUEST_ID   = 4'd3;
    localparam logic [3:0] REC_ERROR_STATUS = 4'd4;
    localparam logic [3:0] REC_ERROR_INDEX  = 4'd5;
    localparam logic [3:0] REC_OID_PART     = 4'd6;
    localparam logic [3:0] REC_VALUE        = 4'd7;
    localparam logic [3:0] REC_PACKET_END   = 4'd8;

    // Value types reported on value records
    localparam logic [1:0] VT_INTEGER = 2'd0;
    localparam logic [1:0] VT_IP      = 2'd1;
    localparam logic [1:0] VT_NULL    = 2'd2;

    // Parser phases, one-hot
    typedef enum logic [31:0] {
        PH_SEQ_TAG    = 32'h0000_0001,
        PH_SEQ_LEN    = 32'h0000_0002,
        PH_VER_TAG    = 32'h0000_0004,
        PH_VER_LEN    = 32'h0000_0008,
        PH_VER_VAL    = 32'h0000_0010,
        PH_VER_SKIP   = 32'h0000_0020,
        PH_COMM_TAG   = 32'h0000_0040,
        PH_COMM_LEN   = 32'h0000_0080,
        PH_COMM_BYTES = 32'h0000_0100,
        PH_PDU_TAG    = 32'h0000_0200,
        PH_PDU_LEN    = 32'h0000_0400,
        PH_INT0_TAG   = 32'h0000_0800,
        PH_INT0_LEN   = 32'h0000_1000,
        PH_INT0_VAL   = 32'h0000_2000,
        PH_INT1_TAG   = 32'h0000_4000,
        PH_INT1_LEN   = 32'h0000_8000,
        PH_INT1_VAL   = 32'h0001_0000,
        PH_INT2_TAG   = 32'h0002_0000,
        PH_INT2_LEN   = 32'h0004_0000,
        PH_INT2_VAL   = 32'h0008_0000,
        PH_VBL_TAG    = 32'h0010_0000,
        PH_VBL_LEN    = 32'h0020_0000,
        PH_VB_TAG     = 32'h0040_0000,
        PH_VB_LEN     = 32'h0080_0000,
        PH_OID_TAG    = 32'h0100_0000,
        PH_OID_LEN    = 32'h0200_0000,
        PH_OID_FIRST  = 32'h0400_0000,
        PH_OID_REST   = 32'h0800_0000,
        PH_VAL_TAG    = 32'h1000_0000,
        PH_VAL_LEN    = 32'h2000_0000,
        PH_VAL_BYTES  = 32'h4000_0000,
        PH_IDLE       = 32'h8000_0000
    } phase_t;

    typedef enum logic [1:0] {
        VK_INT   = 2'd0,
        VK_IP    = 2'd1,
        VK_NULL  = 2'd2,
        VK_OTHER = 2'd3
    } vkind_t;

    typedef enum logic [1:0] {
        OUTCOME_RUNNING  = 2'd0,
        OUTCOME_COMPLETE = 2'd1,
        OUTCOME_FAILED   = 2'd2
    } outcome_t;

    // Parser control state (accumulator travels separately, its width is a parameter)
    typedef struct packed {
        phase_t     phase;
        logic [7:0] field_left;
        logic [7:0] list_left;
        vkind_t     vkind;
        outcome_t   outcome;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_SEQ_TAG,
        field_left: 8'd0,
        list_left:  8'd0,
        vkind:      VK_INT,
        outcome:    OUTCOME_RUNNING
    };

    // Input transfer payload
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_packet;
    } in_item_t;

    // Output transfer payload
    typedef struct packed {
        logic [3:0]  record_kind;
        logic [31:0] record_value;
        logic [1:0]  value_type;
        logic        first_component;
        logic        packet_valid;
        logic        last_result;
    } rec_t;

    function automatic rec_t make_rec(
        input logic [3:0]  kind,
        input logic [31:0] value,
        input logic [1:0]  vtype,
        input logic        first,
        input logic        valid
    );
        rec_t r;
        r.record_kind     = kind;
        r.record_value    = value;
        r.value_type      = vtype;
        r.first_component = first;
        r.packet_valid    = valid;
        r.last_result     = 1'b0;
        return r;
    endfunction

    // Quotient of a byte by the OID radix (0..6), by threshold compares
    function automatic logic [2:0] oid_hi(input logic [7:0] b);
        logic [2:0] q;
        q = 3'd0;
        for (int i = 1; i <= 6; i++)
        begin
            if (b >= 8'(i * OID_RADIX))
            begin
                q = 3'(i);
            end
        end
        return q;
    endfunction

endpackage

// File: hdl/snmp_ber_message_parser_core.sv
// SNMP v1 BER message parser, one datagram byte per input transfer.
// Each byte's records enter the record queue at its transfer and leave it in order.
// Throughput: one byte per cycle while each byte yields at most one record and
// out_ready holds; the output port moves one record per cycle while out_ready is high,
// and in_ready drops while the 4-entry record queue has fewer than three free slots.
// Reset: rst_n (async, active low) returns the parser to the outer sequence tag.
module snmp_ber_message_parser_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  snmpber_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output snmpber_pkg::rec_t      out_data
);
    import snmpber_pkg::*;

    localparam int ACC_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    state_t             state_reg;
    state_t             state_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    rec_t [MAX_RES-1:0] step_recs;
    logic [1:0]         step_count;
    logic [1:0]         push_count;
    logic               in_xfer;
    logic               out_xfer;

    assign in_xfer    = in_valid & in_ready;
    assign out_xfer   = out_valid & out_ready;
    assign push_count = in_xfer ? step_count : 2'd0;

    // Per-byte parse logic
    snmpber_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .in_item   (in_data),
        .state_cur (state_reg),
        .acc_cur   (acc_reg),
        .state_nxt (state_next),
        .acc_nxt   (acc_next),
        .recs      (step_recs),
        .rec_count (step_count)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            acc_reg   <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    // Record queue toward the output port
    snmpber_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_recs  (step_recs),
        .pop        (out_xfer),
        .out_valid  (out_valid),
        .out_rec    (out_data),
        .space_ok   (in_ready)
    );

`ifndef SYNTHESIS
    // A final byte always leaves the parser at the start of a new datagram
    a_eop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.end_of_packet) |=> (state_reg.phase == PH_SEQ_TAG))
        else $error("parser not restarted after final byte");

    // A final byte always produces a record to deliver
    a_eop_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.end_of_packet) |=> out_valid)
        else $error("no record queued after final byte");

    // A settled outcome parks the parser
    a_outcome_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.outcome != OUTCOME_RUNNING) |-> (state_reg.phase == PH_IDLE))
        else $error("outcome settled while parser still active");
`endif

endmodule

// File: hdl/snmpber_step.sv
// Combinational next-state and record generation for one received byte.
// Depends on snmpber_pkg.
module snmpber_step #(
    parameter int VALUE_BITS = 32
) (
    input  snmpber_pkg::in_item_t                      in_item,
    input  snmpber_pkg::state_t                        state_cur,
    input  logic [((VALUE_BITS > 32) ? VALUE_BITS : 32)-1:0] acc_cur,
    output snmpber_pkg::state_t                        state_nxt,
    output logic [((VALUE_BITS > 32) ? VALUE_BITS : 32)-1:0] acc_nxt,
    output snmpber_pkg::rec_t [snmpber_pkg::MAX_RES-1:0] recs,
    output logic [1:0]                                 rec_count
);
    import snmpber_pkg::*;

    localparam int ACC_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam logic [ACC_W-1:0] INT_MASK = {ACC_W{1'b1}} >> (ACC_W - VALUE_BITS);
    localparam logic [ACC_W-1:0] IP_MASK  = {ACC_W{1'b1}} >> (ACC_W - 32);

    state_t            st;
    phase_t            ph;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  shifted;
    logic [7:0]        b;
    logic [7:0]        field_dec;
    logic [2:0]        oid_q;
    logic [7:0]        oid_r;
    logic              done;
    logic              in_list_body;
    logic [3:0]        int_kind;
    phase_t            int_len;
    phase_t            int_val;
    phase_t            int_next;
    rec_t [MAX_RES-1:0] rr;
    logic [1:0]        cnt;

    assign b       = in_item.byte_in;
    assign shifted = {acc_cur[ACC_W-9:0], b};
    assign oid_q   = oid_hi(b);
    assign oid_r   = b - 8'(oid_q * OID_RADIX);

    // Varbind-list byte counting covers the phases inside the list
    assign in_list_body = state_cur.phase inside {PH_VB_TAG, PH_VB_LEN, PH_OID_TAG,
        PH_OID_LEN, PH_OID_FIRST, PH_OID_REST, PH_VAL_TAG, PH_VAL_LEN, PH_VAL_BYTES};

    always_comb
    begin
        st        = state_cur;
        acc       = acc_cur;
        ph        = state_cur.phase;
        rr        = '0;
        cnt       = 2'd0;
        done      = 1'b0;
        field_dec = state_cur.field_left - 8'd1;
        int_kind  = REC_REQUEST_ID;
        int_len   = PH_INT0_LEN;
        int_val   = PH_INT0_VAL;
        int_next  = PH_INT1_TAG;

        if (in_list_body && state_cur.list_left != 8'd0)
        begin
            st.list_left = state_cur.list_left - 8'd1;
        end

        // Phases that may emit and may hand the same byte on to the next field
        if (ph == PH_VER_TAG && b != TAG_INTEGER)
        begin
            ph = PH_COMM_TAG;
        end
        else if (ph == PH_VER_VAL)
        begin
            rr[cnt] = make_rec(REC_VERSION, 32'(b), VT_INTEGER, 1'b0, 1'b0);
            cnt = cnt + 2'd1;
            if (state_cur.field_left == 8'd0)
            begin
                ph = PH_COMM_TAG;
            end
            else
            begin
                done = 1'b1;
                if (state_cur.field_left == 8'd1)
                begin
                    st.phase = PH_COMM_TAG;
                end
                else
                begin
                    st.field_left = field_dec;
                    st.phase = PH_VER_SKIP;
                end
            end
        end
        else if (ph == PH_OID_FIRST)
        begin
            rr[cnt] = make_rec(REC_OID_PART, 32'(oid_q), VT_INTEGER, 1'b1, 1'b0);
            cnt = cnt + 2'd1;
            rr[cnt] = make_rec(REC_OID_PART, 32'(oid_r), VT_INTEGER, 1'b0, 1'b0);
            cnt = cnt + 2'd1;
            if (state_cur.field_left == 8'd0)
            begin
                ph = PH_VAL_TAG;
            end
            else
            begin
                done = 1'b1;
                if (state_cur.field_left == 8'd1)
                begin
                    st.phase = PH_VAL_TAG;
                end
                else
                begin
                    st.field_left = field_dec;
                    st.phase = PH_OID_REST;
                end
            end
        end

        if (!done)
        begin
            // Skip fields whose tag does not match
            if (ph == PH_COMM_TAG && b != TAG_OCTET_STRING) ph = PH_PDU_TAG;
            if (ph == PH_INT0_TAG && b != TAG_INTEGER) ph = PH_INT1_TAG;
            if (ph == PH_INT1_TAG && b != TAG_INTEGER) ph = PH_INT2_TAG;
            if (ph == PH_INT2_TAG && b != TAG_INTEGER) ph = PH_VBL_TAG;
            if (ph == PH_OID_TAG && b != TAG_OID) ph = PH_VB_TAG;

            // Which integer header field this is
            unique case (ph) inside
                PH_INT1_TAG, PH_INT1_LEN, PH_INT1_VAL:
                begin
                    int_kind = REC_ERROR_STATUS;
                    int_len  = PH_INT1_LEN;
                    int_val  = PH_INT1_VAL;
                    int_next = PH_INT2_TAG;
                end
                PH_INT2_TAG, PH_INT2_LEN, PH_INT2_VAL:
                begin
                    int_kind = REC_ERROR_INDEX;
                    int_len  = PH_INT2_LEN;
                    int_val  = PH_INT2_VAL;
                    int_next = PH_VBL_TAG;
                end
                default: ;
            endcase

            st.phase = ph;

            // Handle the byte in the resolved phase
            unique case (ph) inside
                PH_SEQ_TAG:
                begin
                    if (b == TAG_SEQUENCE)
                    begin
                        st.phase = PH_SEQ_LEN;
                    end
                    else
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_FAILED;
                    end
                end
                PH_SEQ_LEN:  st.phase = PH_VER_TAG;
                PH_VER_TAG:  st.phase = PH_VER_LEN;
                PH_VER_LEN:
                begin
                    st.field_left = b;
                    st.phase = PH_VER_VAL;
                end
                PH_VER_SKIP:
                begin
                    st.field_left = field_dec;
                    if (field_dec == 8'd0) st.phase = PH_COMM_TAG;
                end
                PH_COMM_TAG: st.phase = PH_COMM_LEN;
                PH_COMM_LEN:
                begin
                    st.field_left = b;
                    st.phase = (b != 8'd0) ? PH_COMM_BYTES : PH_PDU_TAG;
                end
                PH_COMM_BYTES:
                begin
                    rr[cnt] = make_rec(REC_COMMUNITY, 32'(b), VT_INTEGER, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    st.field_left = field_dec;
                    if (field_dec == 8'd0) st.phase = PH_PDU_TAG;
                end
                PH_PDU_TAG:
                begin
                    if (b >= TAG_GET && b <= TAG_SET)
                    begin
                        rr[cnt] = make_rec(REC_PDU_KIND, 32'(b[1:0]), VT_INTEGER, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                        st.phase = PH_PDU_LEN;
                    end
                    else
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_FAILED;
                    end
                end
                PH_PDU_LEN:  st.phase = PH_INT0_TAG;
                PH_INT0_TAG, PH_INT1_TAG, PH_INT2_TAG:
                begin
                    st.phase = int_len;
                end
                PH_INT0_LEN, PH_INT1_LEN, PH_INT2_LEN:
                begin
                    st.field_left = b;
                    acc = '0;
                    if (b == 8'd0)
                    begin
                        rr[cnt] = make_rec(int_kind, 32'd0, VT_INTEGER, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                        st.phase = int_next;
                    end
                    else
                    begin
                        st.phase = int_val;
                    end
                end
                PH_INT0_VAL, PH_INT1_VAL, PH_INT2_VAL:
                begin
                    acc = shifted & INT_MASK;
                    st.field_left = field_dec;
                    if (field_dec == 8'd0)
                    begin
                        rr[cnt] = make_rec(int_kind, acc[31:0], VT_INTEGER, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                        st.phase = int_next;
                    end
                end
                PH_VBL_TAG:
                begin
                    if (b == TAG_SEQUENCE)
                    begin
                        st.phase = PH_VBL_LEN;
                    end
                    else
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_COMPLETE;
                    end
                end
                PH_VBL_LEN:
                begin
                    st.list_left = b;
                    if (b == 8'd0)
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_COMPLETE;
                    end
                    else
                    begin
                        st.phase = PH_VB_TAG;
                    end
                end
                PH_VB_TAG:
                begin
                    // List end checked on the count before this byte
                    if (state_cur.list_left == 8'd0)
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_COMPLETE;
                    end
                    else if (b == TAG_SEQUENCE)
                    begin
                        st.phase = PH_VB_LEN;
                    end
                    else if (st.list_left == 8'd0)
                    begin
                        st.phase = PH_IDLE;
                        st.outcome = OUTCOME_COMPLETE;
                    end
                end
                PH_VB_LEN:   st.phase = PH_OID_TAG;
                PH_OID_TAG:  st.phase = PH_OID_LEN;
                PH_OID_LEN:
                begin
                    st.field_left = b;
                    st.phase = PH_OID_FIRST;
                end
                PH_OID_REST:
                begin
                    rr[cnt] = make_rec(REC_OID_PART, 32'(b), VT_INTEGER, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                    st.field_left = field_dec;
                    if (field_dec == 8'd0) st.phase = PH_VAL_TAG;
                end
                PH_VAL_TAG:
                begin
                    if (b == TAG_INTEGER)
                        st.vkind = VK_INT;
                    else if (b == TAG_IP_ADDRESS)
                        st.vkind = VK_IP;
                    else if (b == TAG_NULL)
                        st.vkind = VK_NULL;
                    else
                        st.vkind = VK_OTHER;
                    st.phase = PH_VAL_LEN;
                end
                PH_VAL_LEN:
                begin
                    st.field_left = b;
                    acc = '0;
                    if (state_cur.vkind == VK_NULL)
                    begin
                        // Null takes only tag and length
                        rr[cnt] = make_rec(REC_VALUE, 32'd0, VT_NULL, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    else if (state_cur.vkind == VK_OTHER)
                    begin
                        rr[cnt] = make_rec(REC_VALUE, 32'd0, VT_NULL, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    else if (b == 8'd0)
                    begin
                        rr[cnt] = make_rec(REC_VALUE, 32'd0, state_cur.vkind, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    else if (state_cur.vkind == VK_IP && b != 8'd4)
                    begin
                        // Malformed address: report zero, skip its bytes
                        rr[cnt] = make_rec(REC_VALUE, 32'd0, VT_IP, 1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                        st.vkind = VK_OTHER;
                    end

                    if (state_cur.vkind == VK_NULL || b == 8'd0)
                    begin
                        if (st.list_left == 8'd0)
                        begin
                            st.phase = PH_IDLE;
                            st.outcome = OUTCOME_COMPLETE;
                        end
                        else
                        begin
                            st.phase = PH_VB_TAG;
                        end
                    end
                    else
                    begin
                        st.phase = PH_VAL_BYTES;
                    end
                end
                PH_VAL_BYTES:
                begin
                    acc = (state_cur.vkind == VK_IP) ? (shifted & IP_MASK)
                                                     : (shifted & INT_MASK);
                    st.field_left = field_dec;
                    if (field_dec == 8'd0)
                    begin
                        if (state_cur.vkind == VK_INT || state_cur.vkind == VK_IP)
                        begin
                            rr[cnt] = make_rec(REC_VALUE, acc[31:0], state_cur.vkind,
                                               1'b0, 1'b0);
                            cnt = cnt + 2'd1;
                        end
                        if (st.list_left == 8'd0)
                        begin
                            st.phase = PH_IDLE;
                            st.outcome = OUTCOME_COMPLETE;
                        end
                        else
                        begin
                            st.phase = PH_VB_TAG;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Final byte: packet-end record, then back to reset state
        if (in_item.end_of_packet)
        begin
            rr[cnt] = make_rec(REC_PACKET_END, 32'd0, VT_INTEGER, 1'b0,
                               st.outcome == OUTCOME_COMPLETE);
            cnt = cnt + 2'd1;
            st  = STATE_RESET;
            acc = '0;
        end

        if (cnt != 2'd0)
        begin
            rr[cnt - 2'd1].last_result = 1'b1;
        end
    end

    assign state_nxt = st;
    assign acc_nxt   = acc;
    assign recs      = rr;
    assign rec_count = cnt;

endmodule

// File: hdl/snmpber_fifo.sv
// Small record queue between the parser and the output port; takes up to
// three records per cycle and delivers one. Depends on snmpber_pkg.
module snmpber_fifo (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [1:0]                                  push_count,
    input  snmpber_pkg::rec_t [snmpber_pkg::MAX_RES-1:0] push_recs,
    input  logic                                        pop,
    output logic                                        out_valid,
    output snmpber_pkg::rec_t                           out_rec,
    output logic                                        space_ok
);
    import snmpber_pkg::*;

    rec_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pointer and occupancy update
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (i < push_count)
            begin
                mem_reg[PTR_W'(wr_ptr_reg + PTR_W'(i))] <= push_recs[i];
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_rec   = mem_reg[rd_ptr_reg];
    assign space_ok  = (count_reg <= CNT_W'(SPACE_LIMIT));

endmodule

// File: verif/record_checker.sv
`timescale 1ns / 100ps
// Record checker for the SNMP BER parser: watches both channels, predicts records.
// Depends on snmpber_pkg for the payload types, tags, record kinds and phase codes.
module record_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  snmpber_pkg::in_item_t in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  snmpber_pkg::rec_t     out_data,
    output int                    fail_count,
    output int                    pending
);
    import snmpber_pkg::*;

    // value_type carried by records that are not values
    localparam logic [1:0] NO_TYPE = 2'd0;

    // Predictor state
    phase_t     phase;
    logic [7:0] fld_left;
    logic [7:0] list_left;
    logic [31:0] acc;
    vkind_t     vtag;
    outcome_t   outcome;

    rec_t records_due[$];
    rec_t byte_recs[$];
    rec_t want;
    int   errors = 0;

    assign fail_count = errors;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
        begin
            report($sformatf("%s got %0h expected %0h", name, got, exp_val));
        end
    endtask

    function automatic void note(input logic [3:0] kind, input logic [31:0] value,
                                 input logic [1:0] vtype, input logic first,
                                 input logic valid);
        rec_t r;
        if (byte_recs.size() < MAX_RES)
        begin
            r.record_kind     = kind;
            r.record_value    = value;
            r.value_type      = vtype;
            r.first_component = first;
            r.packet_valid    = valid;
            r.last_result     = 1'b0;
            byte_recs.insert(byte_recs.size(), r);
        end
    endfunction

    function automatic void restart_parser();
        phase     = PH_SEQ_TAG;
        fld_left  = 8'd0;
        list_left = 8'd0;
        acc       = 32'd0;
        vtag      = VK_INT;
        outcome   = OUTCOME_RUNNING;
    endfunction

    function automatic void close_packet(input outcome_t o);
        outcome = o;
        phase   = PH_IDLE;
    endfunction

    // End of one varbind: the list either runs on or is done
    function automatic void bind_done();
        if (list_left == 8'd0)
        begin
            close_packet(OUTCOME_COMPLETE);
        end
        else
        begin
            phase = PH_VB_TAG;
        end
    endfunction

    // Phase that follows each of the three integer fields
    function automatic phase_t after_int(input phase_t p);
        case (p)
            PH_INT0_TAG, PH_INT0_LEN, PH_INT0_VAL: return PH_INT1_TAG;
            PH_INT1_TAG, PH_INT1_LEN, PH_INT1_VAL: return PH_INT2_TAG;
            default:                               return PH_VBL_TAG;
        endcase
    endfunction

    function automatic logic [3:0] int_kind(input phase_t p);
        case (p)
            PH_INT0_TAG, PH_INT0_LEN, PH_INT0_VAL: return REC_REQUEST_ID;
            PH_INT1_TAG, PH_INT1_LEN, PH_INT1_VAL: return REC_ERROR_STATUS;
            default:                               return REC_ERROR_INDEX;
        endcase
    endfunction

    // Advance the parser by one datagram byte and queue the records it causes
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [7:0] pre_left;
        logic       again;
        pre_left = list_left;
        byte_recs.delete();
        if (phase >= PH_VB_TAG && phase <= PH_VAL_BYTES && list_left != 8'd0)
        begin
            list_left = list_left - 8'd1;
        end
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (phase)
                PH_SEQ_TAG:
                begin
                    if (b == TAG_SEQUENCE) phase = PH_SEQ_LEN;
                    else close_packet(OUTCOME_FAILED);
                end
                PH_SEQ_LEN: phase = PH_VER_TAG;
                PH_VER_TAG:
                begin
                    if (b == TAG_INTEGER)
                    begin
                        phase = PH_VER_LEN;
                    end
                    else
                    begin
                        phase = PH_COMM_TAG;
                        again = 1'b1;
                    end
                end
                PH_VER_LEN:
                begin
                    fld_left = b;
                    phase    = PH_VER_VAL;
                end
                PH_VER_VAL:
                begin
                    note(REC_VERSION, 32'(b), NO_TYPE, 1'b0, 1'b0);
                    // zero length: this byte is also the next tag
                    if (fld_left == 8'd0)
                    begin
                        phase = PH_COMM_TAG;
                        again = 1'b1;
                    end
                    else if (fld_left == 8'd1)
                    begin
                        phase = PH_COMM_TAG;
                    end
                    else
                    begin
                        fld_left = fld_left - 8'd1;
                        phase    = PH_VER_SKIP;
                    end
                end
                PH_VER_SKIP:
                begin
                    fld_left = fld_left - 8'd1;
                    if (fld_left == 8'd0) phase = PH_COMM_TAG;
                end
                PH_COMM_TAG:
                begin
                    if (b == TAG_OCTET_STRING)
                    begin
                        phase = PH_COMM_LEN;
                    end
                    else
                    begin
                        phase = PH_PDU_TAG;
                        again = 1'b1;
                    end
                end
                PH_COMM_LEN:
                begin
                    fld_left = b;
                    phase    = (b != 8'd0) ? PH_COMM_BYTES : PH_PDU_TAG;
                end
                PH_COMM_BYTES:
                begin
                    note(REC_COMMUNITY, 32'(b), NO_TYPE, 1'b0, 1'b0);
                    fld_left = fld_left - 8'd1;
                    if (fld_left == 8'd0) phase = PH_PDU_TAG;
                end
                PH_PDU_TAG:
                begin
                    if (b >= TAG_GET && b <= TAG_SET)
                    begin
                        note(REC_PDU_KIND, 32'(b - TAG_GET), NO_TYPE, 1'b0, 1'b0);
                        phase = PH_PDU_LEN;
                    end
                    else
                    begin
                        close_packet(OUTCOME_FAILED);
                    end
                end
                PH_PDU_LEN: phase = PH_INT0_TAG;
                // request id, error status, error index
                PH_INT0_TAG, PH_INT1_TAG, PH_INT2_TAG:
                begin
                    if (b == TAG_INTEGER)
                    begin
                        phase = phase_t'(phase << 1);
                    end
                    else
                    begin
                        phase = after_int(phase);
                        again = 1'b1;
                    end
                end
                PH_INT0_LEN, PH_INT1_LEN, PH_INT2_LEN:
                begin
                    fld_left = b;
                    acc      = 32'd0;
                    if (b == 8'd0)
                    begin
                        note(int_kind(phase), 32'd0, NO_TYPE, 1'b0, 1'b0);
                        phase = after_int(phase);
                    end
                    else
                    begin
                        phase = phase_t'(phase << 1);
                    end
                end
                PH_INT0_VAL, PH_INT1_VAL, PH_INT2_VAL:
                begin
                    acc      = {acc[23:0], b};
                    fld_left = fld_left - 8'd1;
                    if (fld_left == 8'd0)
                    begin
                        note(int_kind(phase), acc, NO_TYPE, 1'b0, 1'b0);
                        phase = after_int(phase);
                    end
                end
                PH_VBL_TAG:
                begin
                    if (b == TAG_SEQUENCE) phase = PH_VBL_LEN;
                    else close_packet(OUTCOME_COMPLETE);
                end
                PH_VBL_LEN:
                begin
                    list_left = b;
                    if (b == 8'd0) close_packet(OUTCOME_COMPLETE);
                    else phase = PH_VB_TAG;
                end
                PH_VB_TAG:
                begin
                    if (pre_left == 8'd0) close_packet(OUTCOME_COMPLETE);
                    else if (b == TAG_SEQUENCE) phase = PH_VB_LEN;
                    else if (list_left == 8'd0) close_packet(OUTCOME_COMPLETE);
                end
                PH_VB_LEN: phase = PH_OID_TAG;
                PH_OID_TAG:
                begin
                    if (b == TAG_OID)
                    begin
                        phase = PH_OID_LEN;
                    end
                    else
                    begin
                        phase = PH_VB_TAG;
                        again = 1'b1;
                    end
                end
                PH_OID_LEN:
                begin
                    fld_left = b;
                    phase    = PH_OID_FIRST;
                end
                PH_OID_FIRST:
                begin
                    note(REC_OID_PART, 32'(b / OID_RADIX), NO_TYPE, 1'b1, 1'b0);
                    note(REC_OID_PART, 32'(b % OID_RADIX), NO_TYPE, 1'b0, 1'b0);
                    if (fld_left == 8'd0)
                    begin
                        phase = PH_VAL_TAG;
                        again = 1'b1;
                    end
                    else if (fld_left == 8'd1)
                    begin
                        phase = PH_VAL_TAG;
                    end
                    else
                    begin
                        fld_left = fld_left - 8'd1;
                        phase    = PH_OID_REST;
                    end
                end
                PH_OID_REST:
                begin
                    note(REC_OID_PART, 32'(b), NO_TYPE, 1'b0, 1'b0);
                    fld_left = fld_left - 8'd1;
                    if (fld_left == 8'd0) phase = PH_VAL_TAG;
                end
                PH_VAL_TAG:
                begin
                    if (b == TAG_INTEGER) vtag = VK_INT;
                    else if (b == TAG_IP_ADDRESS) vtag = VK_IP;
                    else if (b == TAG_NULL) vtag = VK_NULL;
                    else vtag = VK_OTHER;
                    phase = PH_VAL_LEN;
                end
                PH_VAL_LEN:
                begin
                    fld_left = b;
                    acc      = 32'd0;
                    if (vtag == VK_NULL)
                    begin
                        // null never skips its body
                        note(REC_VALUE, 32'd0, VT_NULL, 1'b0, 1'b0);
                        bind_done();
                    end
                    else
                    begin
                        if (vtag == VK_OTHER)
                        begin
                            note(REC_VALUE, 32'd0, VT_NULL, 1'b0, 1'b0);
                        end
                        else if (b == 8'd0)
                        begin
                            note(REC_VALUE, 32'd0, (vtag == VK_IP) ? VT_IP : VT_INTEGER,
                                 1'b0, 1'b0);
                        end
                        else if (vtag == VK_IP && b != 8'd4)
                        begin
                            // odd-sized address: report zero, skip its bytes
                            note(REC_VALUE, 32'd0, VT_IP, 1'b0, 1'b0);
                            vtag = VK_OTHER;
                        end
                        if (b == 8'd0) bind_done();
                        else phase = PH_VAL_BYTES;
                    end
                end
                PH_VAL_BYTES:
                begin
                    acc      = {acc[23:0], b};
                    fld_left = fld_left - 8'd1;
                    if (fld_left == 8'd0)
                    begin
                        if (vtag == VK_INT || vtag == VK_IP)
                        begin
                            note(REC_VALUE, acc, (vtag == VK_IP) ? VT_IP : VT_INTEGER,
                                 1'b0, 1'b0);
                        end
                        bind_done();
                    end
                end
                default: ;
            endcase
        end
        if (eop)
        begin
            note(REC_PACKET_END, 32'd0, NO_TYPE, 1'b0, outcome == OUTCOME_COMPLETE);
            restart_parser();
        end
        if (byte_recs.size() > 0)
        begin
            byte_recs[byte_recs.size() - 1].last_result = 1'b1;
        end
        foreach (byte_recs[i])
        begin
            records_due.insert(records_due.size(), byte_recs[i]);
        end
    endtask

    // Compare each record transfer, then predict from each byte transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parser();
            records_due.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (records_due.size() == 0)
                begin
                    report($sformatf("unexpected record kind %0d value %0h",
                                     out_data.record_kind, out_data.record_value));
                end
                else
                begin
                    want = records_due.pop_front();
                    check_field("record_kind", 32'(out_data.record_kind),
                                32'(want.record_kind));
                    check_field("record_value", out_data.record_value, want.record_value);
                    check_field("value_type", 32'(out_data.value_type),
                                32'(want.value_type));
                    check_field("first_component", 32'(out_data.first_component),
                                32'(want.first_component));
                    check_field("packet_valid", 32'(out_data.packet_valid),
                                32'(want.packet_valid));
                    check_field("last_result", 32'(out_data.last_result),
                                32'(want.last_result));
                end
            end
            if (in_valid && in_ready)
            begin
                parse_byte(in_data.byte_in, in_data.end_of_packet);
            end
            pending <= records_due.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the SNMP BER parser: clock, reset, datagram stimulus, verdict.
// Depends on snmpber_pkg, snmp_ber_message_parser_core and record_checker.
module tb_top;
    import snmpber_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 170;
    localparam int TAIL_CYCLES  = 16;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_item_t in_data;
    logic     out_valid;
    logic     out_ready;
    rec_t     out_data;

    int         fail_count;
    int         pending;
    int         stall_cycles = 0;
    logic       calm;
    logic [7:0] frame[$];
    int         sent;

    snmp_ber_message_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    record_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Record sink with random back-pressure
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 29);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{byte_in: b, end_of_packet: eop};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (frame[i])
        begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // Append one byte to the datagram under construction
    task automatic put_byte(input logic [7:0] v);
        frame.insert(frame.size(), v);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Integer lengths: mostly short, some past 32 bits to check truncation
    function automatic int pick_int_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r < 4) return 1;
        if (r < 6) return 2;
        if (r < 8) return $urandom_range(3, 4);
        return 5;
    endfunction

    // One datagram with random content, fields occasionally left out
    task automatic build_message();
        int n;
        int nb;
        int list_at;
        int bind_at;
        int total;
        logic [7:0] others[4];
        others = '{TAG_OCTET_STRING, 8'h41, 8'h43, TAG_OID};
        frame.delete();
        put_byte(TAG_SEQUENCE);
        add_random(1);
        if ($urandom_range(0, 9) != 0)
        begin
            put_byte(TAG_INTEGER);
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
            put_byte(8'(n));
            add_random(n);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            put_byte(TAG_OCTET_STRING);
            n = $urandom_range(0, 3);
            put_byte(8'(n));
            add_random(n);
        end
        put_byte(8'(TAG_GET + $urandom_range(0, 3)));
        add_random(1);
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                put_byte(TAG_INTEGER);
                n = pick_int_len();
                put_byte(8'(n));
                add_random(n);
            end
        end
        // varbind list, lengths patched once the body is known
        if ($urandom_range(0, 9) != 0)
        begin
            put_byte(TAG_SEQUENCE);
            list_at = frame.size();
            put_byte(8'd0);
            nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
            for (int v = 0; v < nb; v++)
            begin
                put_byte(TAG_SEQUENCE);
                bind_at = frame.size();
                put_byte(8'd0);
                put_byte(TAG_OID);
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                put_byte(8'(n));
                add_random(n);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        put_byte(TAG_INTEGER);
                        n = pick_int_len();
                    end
                    1:
                    begin
                        put_byte(TAG_IP_ADDRESS);
                        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
                    end
                    2:
                    begin
                        put_byte(TAG_NULL);
                        n = ($urandom_range(0, 9) == 0) ? 1 : 0;
                    end
                    default:
                    begin
                        put_byte(others[$urandom_range(0, 3)]);
                        n = $urandom_range(0, 3);
                    end
                endcase
                put_byte(8'(n));
                add_random(n);
                frame[bind_at] = 8'(frame.size() - bind_at - 1);
            end
            total = frame.size() - list_at - 1;
            if ($urandom_range(0, 4) == 0)
            begin
                total = total + $urandom_range(0, 6) - 3;
                if (total < 0) total = 0;
            end
            frame[list_at] = 8'(total);
        end
        // bytes past the end of parsing
        if ($urandom_range(0, 9) == 0) add_random($urandom_range(1, 3));
    endtask

    // Sometimes corrupt one byte or cut the datagram short
    task automatic damage_frame();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (r < 20)
        begin
            k = $urandom_range(1, frame.size() - 1);
            while (frame.size() > k) void'(frame.pop_back());
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        calm      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // bad outer tag
        frame = '{8'hFF};
        send_frame();
        // zero-length version and integer, missing varbind list tag
        frame = '{8'h30, 8'h10, 8'h02, 8'h00, 8'h04, 8'h00, 8'hA1, 8'h00,
                  8'h02, 8'h00, 8'h02, 8'h01, 8'hFF, 8'h05};
        send_frame();
        // unknown PDU tag
        frame = '{8'h30, 8'h00, 8'h02, 8'h01, 8'h00, 8'h04, 8'h00, 8'hB0};
        send_frame();
        // truncated datagram
        frame = '{8'h30, 8'h05, 8'h02};
        send_frame();

        // random datagrams, with a stretch free of gaps on both sides
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            calm <= (sent >= 80 && sent < 140);
            if ($urandom_range(0, 99) < 15)
            begin
                frame.delete();
                add_random($urandom_range(1, 5));
            end
            else
            begin
                build_message();
                damage_frame();
            end
            sent = sent + frame.size();
            send_frame();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/snmpber_pkg.sv
hdl/snmpber_step.sv
hdl/snmpber_fifo.sv
hdl/snmp_ber_message_parser_core.sv
verif/record_checker.sv
verif/tb_top.sv
